/* src/cmsc_pkg.sv */
`timescale 1ns / 1ps
package cmsc_pkg;

  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned SHIFT_W = 6;
  // Rounded numerator (target << 32) + freq/2 fits in 63 bits.
  localparam int unsigned NUM_W   = 63;
  // 5 * scale needs 19 bits; its product with freq needs 51.
  localparam int unsigned MAXSEC_W = 19;
  localparam int unsigned PROD_W   = 51;
  localparam int unsigned SPAN_W   = PROD_W - FREQ_W;

  localparam logic [29:0] TARGET_US = 30'd1000000;
  localparam logic [29:0] TARGET_NS = 30'd1000000000;
  localparam logic [SHIFT_W-1:0] FIXED_SHIFT = 6'd20;
  localparam logic [SHIFT_W-1:0] WORD_BITS   = 6'd32;
  localparam logic [2:0] RANGE_FACTOR = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIV,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_MUL,
    SP_LEN
  } span_phase_t;

  typedef struct packed {
    logic               done;
    logic [SHIFT_W-1:0] acc;
  } span_stat_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_stat_t;

endpackage

/* src/clock_mult_shift_calc_top.sv */
`timescale 1ns / 1ps
// Counter conversion calculator: multiplier/shift pairs for microseconds and
// nanoseconds from a counter frequency and a range scale.
// Input channel: in_valid / in_stall with freq_hz and scale. A transfer takes
// place at a rising edge with in_valid high and in_stall low. in_stall is high
// during reset and from the transfer until the item's result has moved into
// the output register.
// Output channel: out_valid / out_stall with mult_us, shift_us, mult_ns,
// nsec_shift; one result per input item, held steady while out_stall is high.
// Sequence: each trial division runs on a bit-serial divider (setup, 63
// quotient bits, result). With a scale of 1 there is one trial per target at
// the fixed shift of 20. Otherwise a serial multiply and bit-length count
// come first, then one to 32 trials per target. A zero frequency skips both
// and goes straight to the done state with an all-zero result.
// The next item can transfer in as soon as a finished result sits in the output
// register, even while the receiver stalls; a second result then waits until
// that register frees up.
// Reset (rst, synchronous) drops any item in progress and empties the output.
module clock_mult_shift_calc_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cmsc_pkg::FREQ_W-1:0]   freq_hz,
  input  logic [cmsc_pkg::SCALE_W-1:0]  scale,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cmsc_pkg::FREQ_W-1:0]   mult_us,
  output logic [cmsc_pkg::SHIFT_W-1:0]  shift_us,
  output logic [cmsc_pkg::FREQ_W-1:0]   mult_ns,
  output logic [cmsc_pkg::SHIFT_W-1:0]  nsec_shift
);

  cmsc_pkg::state_t state, state_next;

  // item registers
  logic [cmsc_pkg::FREQ_W-1:0]  freq;
  logic                         fixed;
  logic                         tgt;      // 0: microseconds, 1: nanoseconds
  logic [cmsc_pkg::SHIFT_W-1:0] sft;
  logic [cmsc_pkg::SHIFT_W-1:0] acc;
  logic [cmsc_pkg::FREQ_W-1:0]  res_mult_us;
  logic [cmsc_pkg::SHIFT_W-1:0] res_shift_us;
  logic [cmsc_pkg::FREQ_W-1:0]  res_mult_ns;
  logic [cmsc_pkg::SHIFT_W-1:0] res_nsec_shift;

  logic accept;
  logic out_free;
  logic span_start;
  logic div_start;
  logic fits;
  logic take;
  logic [cmsc_pkg::SHIFT_W-1:0] take_shift;
  logic [29:0]                  target;
  logic [cmsc_pkg::NUM_W-1:0]   num;

  cmsc_pkg::span_stat_t span_stat;
  cmsc_pkg::div_stat_t  div_stat;

  assign in_stall = rst || (state != cmsc_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // rounded numerator for the current trial shift
  assign target = tgt ? cmsc_pkg::TARGET_NS : cmsc_pkg::TARGET_US;
  assign num    = (cmsc_pkg::NUM_W'(target) << sft)
                + cmsc_pkg::NUM_W'(freq[cmsc_pkg::FREQ_W-1:1]);

  // quotient qualifies when it fits in acc bits: nothing at or above bit acc
  assign fits = (div_stat.quot >> acc) == '0;
  assign take = fixed || fits || (sft == 6'd1);
  always_comb begin
    priority if (fixed) take_shift = cmsc_pkg::FIXED_SHIFT;
    else if (fits)      take_shift = sft;
    else                take_shift = '0;
  end

  always_comb begin
    state_next = state;
    span_start = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      cmsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (freq_hz == '0) begin
            state_next = cmsc_pkg::ST_DONE;
          end else if (scale == 16'd1) begin
            state_next = cmsc_pkg::ST_DIV;
          end else begin
            state_next = cmsc_pkg::ST_SPAN;
            span_start = 1'b1;
          end
        end
      end
      cmsc_pkg::ST_SPAN: begin
        if (span_stat.done) state_next = cmsc_pkg::ST_DIV;
      end
      cmsc_pkg::ST_DIV: begin
        div_start  = 1'b1;
        state_next = cmsc_pkg::ST_DIV_WAIT;
      end
      cmsc_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (take && tgt) state_next = cmsc_pkg::ST_DONE;
          else             state_next = cmsc_pkg::ST_DIV;
        end
      end
      cmsc_pkg::ST_DONE: begin
        if (out_free) state_next = cmsc_pkg::ST_IDLE;
      end
      default: state_next = cmsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cmsc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cmsc_pkg::ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall)                        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      freq           <= freq_hz;
      fixed          <= (scale == 16'd1);
      tgt            <= 1'b0;
      sft            <= (scale == 16'd1) ? cmsc_pkg::FIXED_SHIFT : cmsc_pkg::WORD_BITS;
      res_mult_us    <= '0;
      res_shift_us   <= '0;
      res_mult_ns    <= '0;
      res_nsec_shift <= '0;
    end
    if (state == cmsc_pkg::ST_SPAN && span_stat.done) acc <= span_stat.acc;
    if (state == cmsc_pkg::ST_DIV_WAIT && div_stat.done) begin
      if (take) begin
        // keep this trial, then restart the search for the next target
        if (tgt) begin
          res_mult_ns    <= div_stat.quot[cmsc_pkg::FREQ_W-1:0];
          res_nsec_shift <= take_shift;
        end else begin
          res_mult_us  <= div_stat.quot[cmsc_pkg::FREQ_W-1:0];
          res_shift_us <= take_shift;
        end
        tgt <= 1'b1;
        sft <= fixed ? cmsc_pkg::FIXED_SHIFT : cmsc_pkg::WORD_BITS;
      end else begin
        sft <= sft - 6'd1;
      end
    end
    if (state == cmsc_pkg::ST_DONE && out_free) begin
      mult_us    <= res_mult_us;
      shift_us   <= res_shift_us;
      mult_ns    <= res_mult_ns;
      nsec_shift <= res_nsec_shift;
    end
  end

  cmsc_span u_span (
    .clk   (clk),
    .rst   (rst),
    .start (span_start),
    .freq  (freq_hz),
    .scale (scale),
    .stat  (span_stat)
  );

  cmsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (freq),
    .stat  (div_stat)
  );

endmodule

/* src/cmsc_span.sv */
`timescale 1ns / 1ps
// Shift-add multiply of 5*scale by freq, one multiplier bit a cycle, then a
// bit-length count of the upper part, one bit a cycle.
module cmsc_span (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cmsc_pkg::FREQ_W-1:0]    freq,
  input  logic [cmsc_pkg::SCALE_W-1:0]   scale,
  output cmsc_pkg::span_stat_t           stat
);

  cmsc_pkg::span_phase_t phase, phase_next;

  logic [cmsc_pkg::PROD_W-1:0]   mcand;
  logic [cmsc_pkg::PROD_W-1:0]   prod;
  logic [cmsc_pkg::PROD_W-1:0]   prod_next;
  logic [cmsc_pkg::MAXSEC_W-1:0] mplier;
  logic [4:0]                    cnt;
  logic [cmsc_pkg::SPAN_W-1:0]   span;
  logic [cmsc_pkg::SHIFT_W-1:0]  acc;
  logic                          done;

  assign prod_next = mplier[0] ? (prod + mcand) : prod;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      cmsc_pkg::SP_IDLE: begin
        if (start) phase_next = cmsc_pkg::SP_MUL;
      end
      cmsc_pkg::SP_MUL: begin
        if (cnt == 5'd0) phase_next = cmsc_pkg::SP_LEN;
      end
      cmsc_pkg::SP_LEN: begin
        if (span == '0) phase_next = cmsc_pkg::SP_IDLE;
      end
      default: phase_next = cmsc_pkg::SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cmsc_pkg::SP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == cmsc_pkg::SP_LEN) && (span == '0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      cmsc_pkg::SP_IDLE: begin
        if (start) begin
          mcand  <= cmsc_pkg::PROD_W'(freq);
          mplier <= cmsc_pkg::MAXSEC_W'(scale) * cmsc_pkg::MAXSEC_W'(cmsc_pkg::RANGE_FACTOR);
          prod   <= '0;
          cnt    <= 5'(cmsc_pkg::MAXSEC_W - 1);
          acc    <= cmsc_pkg::WORD_BITS;
        end
      end
      cmsc_pkg::SP_MUL: begin
        prod   <= prod_next;
        mcand  <= {mcand[cmsc_pkg::PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[cmsc_pkg::MAXSEC_W-1:1]};
        cnt    <= cnt - 5'd1;
        if (cnt == 5'd0) span <= prod_next[cmsc_pkg::PROD_W-1:cmsc_pkg::FREQ_W];
      end
      cmsc_pkg::SP_LEN: begin
        // drop one bit of the span per cycle until it is empty
        if (span != '0) begin
          span <= {1'b0, span[cmsc_pkg::SPAN_W-1:1]};
          acc  <= acc - 6'd1;
        end
      end
      default: ;
    endcase
  end

  assign stat.done = done;
  assign stat.acc  = acc;

endmodule

/* src/cmsc_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle. Numerator bits leave the top
// of the work register while quotient bits enter at the bottom.
module cmsc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cmsc_pkg::NUM_W-1:0]   num,
  input  logic [cmsc_pkg::FREQ_W-1:0]  den,
  output cmsc_pkg::div_stat_t          stat
);

  logic [cmsc_pkg::NUM_W-1:0]  work;
  logic [cmsc_pkg::FREQ_W-1:0] rem;
  logic [cmsc_pkg::FREQ_W-1:0] dvs;
  logic [cmsc_pkg::FREQ_W:0]   trial;
  logic [cmsc_pkg::FREQ_W:0]   diff;
  logic                        qbit;
  logic [5:0]                  cnt;
  logic                        active;
  logic                        done;

  assign trial = {rem, work[cmsc_pkg::NUM_W-1]};
  assign qbit  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == 6'd1) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      dvs  <= den;
      rem  <= '0;
      cnt  <= 6'(cmsc_pkg::NUM_W);
    end else if (active) begin
      rem  <= qbit ? diff[cmsc_pkg::FREQ_W-1:0] : trial[cmsc_pkg::FREQ_W-1:0];
      work <= {work[cmsc_pkg::NUM_W-2:0], qbit};
      cnt  <= cnt - 6'd1;
    end
  end

  assign stat.done = done;
  assign stat.quot = work;

endmodule

/* dv/tb_clock_mult_shift_calc_top.sv */
`timescale 1ns / 1ps
module tb_clock_mult_shift_calc_top;

  localparam int unsigned FW = cmsc_pkg::FREQ_W;
  localparam int unsigned SW = cmsc_pkg::SCALE_W;
  localparam int unsigned HW = cmsc_pkg::SHIFT_W;

  // Conversion targets and search constants, kept local to the predictor.
  localparam logic [63:0] US_PER_SEC   = 64'd1000000;
  localparam logic [63:0] NS_PER_SEC   = 64'd1000000000;
  localparam int          FIX_SHIFT    = 20;
  localparam int          RANGE_MUL    = 5;
  localparam int          WORD_LEN     = 32;

  localparam int          RANDOM_ITEMS = 118;
  localparam int          HOLD_CYCLES  = 15000;  // long enough to fill the block twice over
  localparam int          HOLD_AT      = 30;     // results seen before the long hold-off
  localparam int          DRAIN_LIMIT  = 50000;
  localparam int          TAIL_CYCLES  = 300;

  typedef struct packed {
    logic [FW-1:0] mult_us;
    logic [HW-1:0] shift_us;
    logic [FW-1:0] mult_ns;
    logic [HW-1:0] nsec_shift;
  } conv_t;

  typedef struct packed {
    logic [FW-1:0] mult;
    logic [HW-1:0] shift;
  } pair_t;

  typedef struct {
    logic [FW-1:0] freq;
    logic [SW-1:0] scl;
    bit            typed;
    conv_t         want;
  } stim_row_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic [FW-1:0] freq_hz;
  logic [SW-1:0] scale;
  logic          out_valid;
  logic          out_stall;
  logic [FW-1:0] mult_us;
  logic [HW-1:0] shift_us;
  logic [FW-1:0] mult_ns;
  logic [HW-1:0] nsec_shift;

  clock_mult_shift_calc_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .freq_hz    (freq_hz),
    .scale      (scale),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mult_us    (mult_us),
    .shift_us   (shift_us),
    .mult_ns    (mult_ns),
    .nsec_shift (nsec_shift)
  );

  // Expected conversions, oldest first, one per input transfer.
  conv_t     conv_expected[$];
  stim_row_t stim_rows[$];

  int unsigned mismatches  = 0;
  int unsigned results_rx  = 0;
  int unsigned items_sent  = 0;
  int unsigned zero_freq_n = 0;
  int unsigned fixed_n     = 0;
  int unsigned search_n    = 0;
  bit          hold_done   = 0;
  bit          rx_quiet    = 0;
  bit          tx_quiet    = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Rounded quotient ((target << sft) + freq/2) / freq at 64 bits.
  function automatic logic [63:0] round_quot(logic [FW-1:0] freq, logic [63:0] target,
                                             int sft);
    logic [63:0] num;
    num = (target << sft) + {33'd0, freq[FW-1:1]};
    return num / {32'd0, freq};
  endfunction

  // Search the largest shift whose quotient fits in acc bits; fall back to shift 0
  // with the shift-1 quotient when none fits.
  function automatic pair_t search_pair(logic [FW-1:0] freq, logic [63:0] target,
                                        logic [SW-1:0] scl);
    logic [63:0] span;
    logic [63:0] q;
    logic [63:0] q_keep;
    int          acc;
    int          sft;
    bit          found;
    pair_t       p;
    span   = (64'(scl) * RANGE_MUL * {32'd0, freq}) >> WORD_LEN;
    acc    = WORD_LEN;
    q_keep = '0;
    found  = 0;
    p      = '0;
    while (span != 0) begin
      span = span >> 1;
      acc--;
    end
    for (sft = WORD_LEN; sft >= 1; sft--) begin
      if (!found) begin
        q      = round_quot(freq, target, sft);
        q_keep = q;
        if ((q >> acc) == 0) begin
          found   = 1;
          p.shift = HW'(sft);
        end
      end
    end
    p.mult = q_keep[FW-1:0];
    return p;
  endfunction

  function automatic conv_t calc_conversion(logic [FW-1:0] freq, logic [SW-1:0] scl);
    conv_t       c;
    pair_t       pu;
    pair_t       pn;
    logic [63:0] qu;
    logic [63:0] qn;
    c = '0;
    if (freq == 0) return c;
    if (scl == 1) begin
      // Fixed shift: keep only the low word of a possibly wide quotient.
      qu = round_quot(freq, US_PER_SEC, FIX_SHIFT);
      qn = round_quot(freq, NS_PER_SEC, FIX_SHIFT);
      c.mult_us    = qu[FW-1:0];
      c.shift_us   = HW'(FIX_SHIFT);
      c.mult_ns    = qn[FW-1:0];
      c.nsec_shift = HW'(FIX_SHIFT);
    end else begin
      pu = search_pair(freq, US_PER_SEC, scl);
      pn = search_pair(freq, NS_PER_SEC, scl);
      c.mult_us    = pu.mult;
      c.shift_us   = pu.shift;
      c.mult_ns    = pn.mult;
      c.nsec_shift = pn.shift;
    end
    return c;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic add_row(logic [FW-1:0] freq, logic [SW-1:0] scl, bit typed,
                         conv_t want);
    stim_row_t r;
    r.freq  = freq;
    r.scl   = scl;
    r.typed = typed;
    r.want  = want;
    stim_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input side: offer one item, hold it until the transfer, then log what the
  // predictor expects for it.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [FW-1:0] freq, logic [SW-1:0] scl, conv_t want);
    int unsigned gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      // Drop valid for the gap; the edge that ends it starts the next offer.
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    freq_hz  <= freq;
    scale    <= scl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    conv_expected.push_back(want);
    items_sent++;
    if (freq == 0) zero_freq_n++;
    else if (scl == 1) fixed_n++;
    else search_n++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall pattern, one long hold-off, one quiet stretch.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_len;
    int unsigned open_len;
    int unsigned held;
    out_stall = 1'b0;
    forever begin
      if (!hold_done && results_rx >= HOLD_AT) begin
        // Hold off long enough that a result parks in the output register,
        // the next one finishes behind it, and the input stalls.
        hold_done = 1;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        rx_quiet  = (results_rx >= 60 && results_rx < 80);
        stall_len = rx_quiet ? 0 : pick_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      open_len = $urandom_range(1, 8);
      repeat (open_len) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each output transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    conv_t e;
    if (!rst && out_valid && !out_stall) begin
      results_rx <= results_rx + 1;
      if (conv_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: us %h/%0d ns %h/%0d",
                   $realtime, mult_us, shift_us, mult_ns, nsec_shift);
      end else begin
        e = conv_expected.pop_front();
        if (mult_us !== e.mult_us || shift_us !== e.shift_us ||
            mult_ns !== e.mult_ns || nsec_shift !== e.nsec_shift) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d mismatch: exp us %h/%0d ns %h/%0d, got us %h/%0d ns %h/%0d",
                     $realtime, results_rx, e.mult_us, e.shift_us, e.mult_ns, e.nsec_shift,
                     mult_us, shift_us, mult_ns, nsec_shift);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random items, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t   row;
    conv_t       zero_c;
    conv_t       mhz_c;
    logic [FW-1:0] f;
    logic [SW-1:0] s;
    int          i;
    int unsigned waited;

    rst       = 1'b1;
    in_valid  = 1'b0;
    freq_hz   = '0;
    scale     = '0;
    zero_c    = '0;
    // 1 MHz at fixed shift: exactly 2^20 ticks-to-us and 1000 * 2^20 ticks-to-ns.
    mhz_c     = {32'd1048576, 6'd20, 32'd1048576000, 6'd20};

    // Zero frequency gives all zeros whatever the scale.
    add_row(32'd0,          16'd0,     1, zero_c);
    add_row(32'd0,          16'd1,     1, zero_c);
    add_row(32'd0,          16'hFFFF,  1, zero_c);
    add_row(32'd1000000,    16'd1,     1, mhz_c);
    // Slowest counters: wide quotient on the fixed path, zero-scale search.
    add_row(32'd1,          16'd1,     0, zero_c);
    add_row(32'd1,          16'd0,     0, zero_c);
    add_row(32'd1,          16'd2,     0, zero_c);
    add_row(32'd1,          16'hFFFF,  0, zero_c);
    add_row(32'd2,          16'd1,     0, zero_c);
    add_row(32'd3,          16'd5,     0, zero_c);
    // Fastest counter, and the widest range: closest to no shift fitting.
    add_row(32'hFFFFFFFF,   16'd1,     0, zero_c);
    add_row(32'hFFFFFFFF,   16'd0,     0, zero_c);
    add_row(32'hFFFFFFFF,   16'd2,     0, zero_c);
    add_row(32'hFFFFFFFF,   16'hFFFF,  0, zero_c);
    add_row(32'd1000000000, 16'd1,     0, zero_c);
    add_row(32'd1000000000, 16'd2,     0, zero_c);
    add_row(32'h80000000,   16'h8000,  0, zero_c);
    add_row(32'd32768,      16'd10,    0, zero_c);
    add_row(32'd19200000,   16'h5555,  0, zero_c);
    add_row(32'h55555555,   16'hAAAA,  0, zero_c);
    add_row(32'hAAAAAAAA,   16'h5555,  0, zero_c);
    add_row(32'd14318180,   16'd3,     0, zero_c);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < stim_rows.size(); i++) begin
      row = stim_rows[i];
      send_item(row.freq, row.scl,
                row.typed ? row.want : calc_conversion(row.freq, row.scl));
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0:       f = $urandom_range(1, 1000);
        1, 2:    f = $urandom_range(10000, 1000000000);
        3:       f = ($urandom_range(0, 3) == 0) ? 32'd0 : (32'd1 << $urandom_range(0, 31));
        default: f = $urandom();
      endcase
      case ($urandom_range(0, 7))
        0, 1:    s = 16'd1;
        2:       s = SW'($urandom_range(0, 20));
        default: s = SW'($urandom_range(0, 65535));
      endcase
      tx_quiet = (i >= 40 && i < 60);
      send_item(f, s, calc_conversion(f, s));
      if (i == 100) begin
        // Pause the sender until every pending result is out.
        in_valid <= 1'b0;
        do @(posedge clk); while (conv_expected.size() != 0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then give the block a tail to show any stray result.
    waited = 0;
    while (conv_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (conv_expected.size() != 0) begin
      mismatches += conv_expected.size();
      $display("%0d expected results never arrived", conv_expected.size());
    end

    $display("covered %0d items (%0d zero-frequency, %0d fixed-shift, %0d searched), %0d results",
             items_sent, zero_freq_n, fixed_n, search_n, results_rx);
    $display("long output hold-off %0s; %0d mismatches", hold_done ? "done" : "missed",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #80000000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
src/cmsc_pkg.sv
src/cmsc_span.sv
src/cmsc_div.sv
src/clock_mult_shift_calc_top.sv
dv/tb_clock_mult_shift_calc_top.sv
